/* rtl/pnf_pkg.sv */
// ============================================================================
// pnf_pkg: shared types and constants of the pink noise filter
// Coefficient tables, fixed-point widths and the controller/datapath bundles.
// ============================================================================
package pnf_pkg;

    // Filter state: seven Q8.24 registers, six one-pole sections plus one delay.
    localparam int NUM_SECT   = 7;
    localparam int IDX_W      = 3;
    localparam int STATE_W    = 32;
    localparam int FRAC_W     = 24;
    localparam int COEF_W     = 25;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 36;
    localparam int DIVISOR    = 5;

    // Configuration port.
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic [PADDR_W-3:0] REG_GAIN = 1'b0;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd4096;

    typedef logic [IDX_W-1:0] sect_idx_t;

    localparam sect_idx_t SECT_FIRST = 3'd0;
    localparam sect_idx_t SECT_LAST  = 3'd6;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        sect_idx_t idx;
        logic      gain_en;
        logic      rnd_en;
        logic      rcp_en;
        logic      out_load;
    } pnf_cmd_t;

    typedef struct packed {
        logic out_busy;
    } pnf_status_t;

    // Feedback coefficient of each section, Q.24. The last entry is the
    // delay tap gain, which multiplies the white sample instead of state.
    function automatic coef_t coef_pole(input sect_idx_t idx);
        coef_t c;
        case (idx)
            3'd0:    c = 25'sd16758090;
            3'd1:    c = 25'sd16665144;
            3'd2:    c = 25'sd16257122;
            3'd3:    c = 25'sd14537458;
            3'd4:    c = 25'sd9227469;
            3'd5:    c = -25'sd12777528;
            3'd6:    c = 25'sd1944916;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Input coefficient of each section, Q.24. The last entry is the direct
    // path gain applied to the white sample.
    function automatic coef_t coef_in(input sect_idx_t idx);
        coef_t c;
        case (idx)
            3'd0:    c = 25'sd931436;
            3'd1:    c = 25'sd1259565;
            3'd2:    c = 25'sd2581208;
            3'd3:    c = 25'sd5209084;
            3'd4:    c = 25'sd8941454;
            3'd5:    c = -25'sd283501;
            3'd6:    c = 25'sd8995943;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/pnf_ctrl.sv */
// ============================================================================
// pnf_ctrl: sequencer of the pink noise filter
// Steps the datapath through the section updates, gain, rounding and the
// divide-by-five, then hands the sample to the output register.
// ============================================================================
module pnf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pnf_pkg::pnf_status_t status,
    output pnf_pkg::pnf_cmd_t    cmd
);
    import pnf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SECT  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_GAIN  = 3'd3;
    localparam logic [2:0] ST_RND   = 3'd4;
    localparam logic [2:0] ST_RCP   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0] state_reg, state_next;
    sect_idx_t  cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = SECT_FIRST;
                    state_next = ST_SECT;
                end
            end
            ST_SECT: begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == SECT_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            // The datapath folds the last products into the sum here.
            ST_DRAIN: state_next = ST_GAIN;
            ST_GAIN: begin
                cmd.gain_en = 1'b1;
                state_next  = ST_RND;
            end
            ST_RND: begin
                cmd.rnd_en = 1'b1;
                state_next = ST_RCP;
            end
            ST_RCP: begin
                cmd.rcp_en = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= SECT_FIRST;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/pnf_datapath.sv */
// ============================================================================
// pnf_datapath: arithmetic of the pink noise filter
// Section state, the two shared coefficient multipliers, the sum, the gain
// multiplier, rounding and saturation, and the output register.
// ============================================================================
module pnf_datapath #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pnf_pkg::pnf_cmd_t              cmd,
    output pnf_pkg::pnf_status_t           status,
    input  logic [pnf_pkg::GAIN_W-1:0]     gain,
    input  logic signed [SAMPLE_WIDTH-1:0] white_sample,
    output logic signed [SAMPLE_WIDTH-1:0] pink_sample,
    output logic                           pink_valid,
    input  logic                           pink_ready
);
    import pnf_pkg::*;

    localparam int W_W    = FRAC_W + 2;
    localparam int W_SH   = FRAC_W + 1 - SAMPLE_WIDTH;
    localparam int PA_W   = COEF_W + STATE_W;
    localparam int PB_W   = COEF_W + W_W;
    localparam int ACC_W  = PA_W + 1;
    localparam int RS_W   = ACC_W - FRAC_W;
    localparam int RB_W   = PB_W - FRAC_W;
    localparam int T_W    = SUM_W + GAIN_W + 1;
    localparam int MAG_W  = T_W + 1;
    localparam int DSH    = 37 - SAMPLE_WIDTH;
    localparam int XF_W   = MAG_W - DSH;
    localparam int X_W    = SAMPLE_WIDTH + 2;
    localparam int RP_W   = 2 * X_W;

    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_W - 1);
    localparam logic [PB_W-1:0]  PB_HALF  = PB_W'(1) << (FRAC_W - 1);
    localparam logic [MAG_W-1:0] DIV_HALF = MAG_W'(DIVISOR) << (DSH - 1);
    localparam logic [XF_W-1:0]  X_LIMIT  = XF_W'(DIVISOR) << (SAMPLE_WIDTH - 1);
    localparam logic [X_W-1:0]   RCP_M    = X_W'((2 ** X_W) / DIVISOR);
    localparam logic [X_W-1:0]   X_DIV    = X_W'(DIVISOR);
    localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [W_W-1:0]     w_reg;
    logic signed [STATE_W-1:0] sec_reg [NUM_SECT];
    logic signed [PA_W-1:0]    pa_reg;
    logic signed [PB_W-1:0]    pb_reg;
    logic                      pv_reg;
    sect_idx_t                 pidx_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [T_W-1:0]     t_reg;
    logic [X_W-1:0]            x_reg;
    logic                      neg_reg;
    logic                      sat_reg;
    logic [X_W-1:0]            q0_reg;
    logic signed [SAMPLE_WIDTH-1:0] pink_reg;
    logic                      pink_valid_reg;

    logic signed [W_W-1:0]     w_next;
    logic signed [STATE_W-1:0] op_sel;
    logic signed [PA_W-1:0]    pa_next;
    logic signed [PB_W-1:0]    pb_next;
    logic signed [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]          acc_rnd;
    logic [RS_W-1:0]           acc_sh;
    logic signed [STATE_W-1:0] sec_new;
    logic [PB_W-1:0]           pb_rnd;
    logic signed [RB_W-1:0]    pb_q;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [T_W-1:0]     t_next;
    logic signed [MAG_W-1:0]   t_ext;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          biased;
    logic [XF_W-1:0]           xf;
    logic [RP_W-1:0]           rcp_prod;
    logic [X_W-1:0]            five_q;
    logic [X_W-1:0]            rem;
    logic [X_W-1:0]            q_fix;
    logic signed [SAMPLE_WIDTH-1:0] q_val;
    logic signed [SAMPLE_WIDTH-1:0] res;

    // Widen the white sample to Q2.24.
    assign w_next = W_W'(white_sample) <<< W_SH;

    // Multiply stage. The last step multiplies the white sample twice: by
    // the delay tap gain and by the direct path gain.
    always_comb begin
        if (cmd.idx == SECT_LAST) begin
            op_sel = STATE_W'(w_reg);
        end else begin
            op_sel = sec_reg[cmd.idx];
        end
        pa_next = PA_W'(coef_pole(cmd.idx)) * PA_W'(op_sel);
        pb_next = PB_W'(coef_in(cmd.idx)) * PB_W'(w_reg);
    end

    // Accumulate stage: round to Q8.24, saturate, and add into the sum.
    always_comb begin
        if (pidx_reg == SECT_LAST) begin
            acc = ACC_W'(pa_reg);
        end else begin
            acc = ACC_W'(pa_reg) + ACC_W'(pb_reg);
        end
        acc_rnd = acc + ACC_HALF;
        acc_sh  = acc_rnd[ACC_W-1:FRAC_W];
        if ((&acc_sh[RS_W-1:STATE_W-1]) || !(|acc_sh[RS_W-1:STATE_W-1])) begin
            sec_new = $signed(acc_sh[STATE_W-1:0]);
        end else if (acc_sh[RS_W-1]) begin
            sec_new = ST_MIN;
        end else begin
            sec_new = ST_MAX;
        end
        pb_rnd = pb_reg + PB_HALF;
        pb_q   = $signed(pb_rnd[PB_W-1:FRAC_W]);
        // The last step adds the old delay register before it is replaced.
        if (pidx_reg == SECT_LAST) begin
            sum_next = sum_reg + SUM_W'(sec_reg[SECT_LAST]) + SUM_W'(pb_q);
        end else begin
            sum_next = sum_reg + SUM_W'(sec_new);
        end
    end

    assign t_next = T_W'(sum_reg) * T_W'($signed({1'b0, gain}));

    // Round half away from zero: bias the magnitude, drop the power-of-two
    // part of the divisor here and divide by five with a reciprocal later.
    always_comb begin
        t_ext  = MAG_W'(t_reg);
        mag    = t_reg[T_W-1] ? MAG_W'(-t_ext) : MAG_W'(t_ext);
        biased = mag + DIV_HALF;
        xf     = biased[MAG_W-1:DSH];
    end

    assign rcp_prod = RP_W'(x_reg) * RP_W'(RCP_M);

    // The reciprocal quotient is low by at most one; fix it from the remainder.
    always_comb begin
        five_q = X_W'({q0_reg, 2'b00}) + q0_reg;
        rem    = x_reg - five_q;
        q_fix  = q0_reg + X_W'(rem >= X_DIV);
        q_val  = $signed(q_fix[SAMPLE_WIDTH-1:0]);
        if (sat_reg) begin
            res = neg_reg ? S_MIN : S_MAX;
        end else begin
            res = neg_reg ? -q_val : q_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SECT; i++) begin
                sec_reg[i] <= '0;
            end
            pv_reg         <= 1'b0;
            pink_valid_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.mul_en;
            if (pv_reg) begin
                sec_reg[pidx_reg] <= sec_new;
            end
            if (cmd.out_load) begin
                pink_valid_reg <= 1'b1;
            end else if (pink_ready) begin
                pink_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg   <= w_next;
            sum_reg <= '0;
        end else if (pv_reg) begin
            sum_reg <= sum_next;
        end
        if (cmd.mul_en) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pidx_reg <= cmd.idx;
        end
        if (cmd.gain_en) begin
            t_reg <= t_next;
        end
        if (cmd.rnd_en) begin
            neg_reg <= t_reg[T_W-1];
            sat_reg <= (xf >= X_LIMIT);
            x_reg   <= xf[X_W-1:0];
        end
        if (cmd.rcp_en) begin
            q0_reg <= rcp_prod[RP_W-1:X_W];
        end
        if (cmd.out_load) begin
            pink_reg <= res;
        end
    end

    assign status.out_busy = pink_valid_reg && !pink_ready;
    assign pink_sample     = pink_reg;
    assign pink_valid      = pink_valid_reg;

endmodule

/* rtl/pink_noise_filter_core.sv */
// ============================================================================
// pink_noise_filter_core: refined Kellet pink noise filter
// Turns one white noise sample into one pink noise sample per beat, with an
// APB-style register for the output gain.
// ============================================================================
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_white_sample, signed Q1.(W-1)
//  m_       out        m_valid/m_ready    m_pink_sample, signed Q1.(W-1)
//  APB      config     psel/penable       gain at address 0, unsigned Q4.12
//
// An accepted sample steps through the section updates on the two shared coefficient
// multipliers, a drain step to fold the last products into the sum, then gain,
// rounding, divide by five and saturation before it lands in the output register;
// a new beat is taken only once that is done. The next input beat is accepted while a result
// waits; a stalled output holds the sequencer in its last step. Reset is
// synchronous, active low, and clears all filter state and sets unity gain.
module pink_noise_filter_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pnf_pkg::PADDR_W-1:0]          paddr,
    input  logic [pnf_pkg::PDATA_W-1:0]          pwdata,
    output logic [pnf_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_white_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       m_pink_sample
);
    import pnf_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    pnf_cmd_t          cmd;
    pnf_status_t       status;
    logic              gain_sel;

    assign pready   = 1'b1;
    assign gain_sel = (paddr[PADDR_W-1:2] == REG_GAIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (psel && penable && pwrite && pready && gain_sel) begin
            gain_reg <= pwdata[GAIN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (gain_sel) begin
            prdata = PDATA_W'(gain_reg);
        end
    end

    pnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pnf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .gain         (gain_reg),
        .white_sample (s_white_sample),
        .pink_sample  (m_pink_sample),
        .pink_valid   (m_valid),
        .pink_ready   (m_ready)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid && !m_ready))
        else $error("output register loaded while a result is still waiting");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> cmd.mul_en && (cmd.idx == SECT_FIRST))
        else $error("section updates did not start after an accepted beat");

    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mul_en, cmd.gain_en, cmd.rnd_en, cmd.rcp_en,
                  cmd.out_load}))
        else $error("more than one datapath step issued in a cycle");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_en |-> !s_ready)
        else $error("input accepted while sections are being updated");
`endif

endmodule
